/* src/bloom_filter_lfsr_hash_top_macros.svh */
// ----------------------------------------------------------------------------
// bloom filter assertion macros
// shared assertion forms for the bloom filter block
// ----------------------------------------------------------------------------
`ifndef BLOOM_FILTER_LFSR_HASH_TOP_MACROS_SVH
`define BLOOM_FILTER_LFSR_HASH_TOP_MACROS_SVH

// checked at every rising edge outside of reset
`define BLF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every rising edge, reset included
`define BLF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/blf_pkg.sv */
// ----------------------------------------------------------------------------
// blf_pkg
// types, codes and constants of the bloom filter block
// ----------------------------------------------------------------------------
package blf_pkg;

  localparam int FILTER_BYTES_DEF = 1024;
  localparam int HASH_W           = 31;
  localparam int FOLD_BITS        = 13;
  localparam int BYTE_W           = 8;
  localparam int LOG2_W           = 4;
  localparam int PROBE_W          = 6;
  localparam int TOTAL_W          = 16;
  localparam int ADDEND_W         = 9;
  localparam int CFG_IDX_W        = 2;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // item kinds
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_MATCH  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_SEED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG2_BITS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_COUNT = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic [BYTE_W-1:0] key_byte;
    logic              byte_valid;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    logic [PROBE_W-1:0] bits_newly_set;
    logic               present;
    logic [TOTAL_W-1:0] insert_total;
  } out_item_t;

endpackage

/* src/blf_ram.sv */
// ----------------------------------------------------------------------------
// blf_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module blf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/blf_fold.sv */
// ----------------------------------------------------------------------------
// blf_fold
// one step of the 31-bit shift and xor hash plus an addend
// ----------------------------------------------------------------------------
module blf_fold (
  input  logic [blf_pkg::HASH_W-1:0]   s_in,
  input  logic [blf_pkg::ADDEND_W-1:0] addend,
  output logic [blf_pkg::HASH_W-1:0]   s_out
);
  import blf_pkg::*;

  logic [FOLD_BITS-1:0] low;
  logic [HASH_W-1:0]    mixed;

  assign low   = s_in[FOLD_BITS-1:0];
  // high part moves down, low bits feed back at both ends
  assign mixed = (HASH_W'(s_in >> FOLD_BITS))
               ^ {low, {(HASH_W-FOLD_BITS){1'b0}}}
               ^ HASH_W'(low);
  assign s_out = mixed + HASH_W'(addend);

endmodule

/* src/bloom_filter_lfsr_hash_top.sv */
// ----------------------------------------------------------------------------
// bloom_filter_lfsr_hash_top
// bloom filter with a streamed key hash and an iterative probe sequencer
// ----------------------------------------------------------------------------
// usage
//   input channel: one key byte per transfer, kind selects clear, insert or
//   match; last_byte closes the key. a non-last byte leaves the block idle.
//   the last item of an insert or match walks the probes through one shared
//   hash step and the filter ram, one hash state (hash and address the ram)
//   and one check state (test and write back) per probe; a finish state
//   then loads the result register. a match stops at the first clear bit.
//   a clear item, and reset, start a sweep that zeroes one ram byte a cycle
//   over all FILTER_BYTES bytes (1024 by default), with in_stall high.
//   config writes are taken at any time, but belong only to an idle block.
//   a stalled result holds; the next key may still be hashed meanwhile, only
//   its final result load waits for the output register to free up.
//   unused kind three is taken and dropped.
// ----------------------------------------------------------------------------
`include "bloom_filter_lfsr_hash_top_macros.svh"

module bloom_filter_lfsr_hash_top #(
  parameter int FILTER_BYTES = blf_pkg::FILTER_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // config write port
  input  logic                            cfg_we,
  input  logic [blf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [blf_pkg::HASH_W-1:0]      cfg_wdata,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  blf_pkg::in_item_t               in_data,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output blf_pkg::out_item_t              out_data
);
  import blf_pkg::*;

  localparam int ADDR_W = (FILTER_BYTES > 1) ? $clog2(FILTER_BYTES) : 1;
  localparam int BIT_W  = ADDR_W + 3;
  localparam logic [15:0]       FULL_MASK = 16'(8 * FILTER_BYTES - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(FILTER_BYTES - 1);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_HASH   = 5'b00100,
    ST_CHECK  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // config registers
  logic [HASH_W-1:0]  seed_r;
  logic [LOG2_W-1:0]  log2_r;
  logic [PROBE_W-1:0] probes_r;

  // key and probe state
  logic [HASH_W-1:0]  run_r;
  logic               kip_r;
  logic [HASH_W-1:0]  s_r;
  logic [PROBE_W-1:0] remain_r;
  logic               ins_r;
  logic [PROBE_W-1:0] newly_r;
  logic               present_r;
  logic [BIT_W-1:0]   mask_r;
  logic [2:0]         bitsel_r;
  logic [ADDR_W-1:0]  waddr_r;
  logic [ADDR_W-1:0]  clr_cnt_r;
  logic [TOTAL_W-1:0] cnt_r;

  // result register
  logic               out_valid_r;
  out_item_t          out_r;

  // datapath
  logic               in_acc;
  logic               key_item;
  logic               out_free;
  logic [HASH_W-1:0]  h0;
  logic [HASH_W-1:0]  h1;
  logic [HASH_W-1:0]  fold_in;
  logic [ADDEND_W-1:0] fold_add;
  logic [HASH_W-1:0]  fold_out;
  logic [15:0]        wmask;
  logic [15:0]        mask16;
  logic [BIT_W-1:0]   probe_idx;
  logic               bit_set;
  logic [TOTAL_W-1:0] cnt_inc;

  // ram ports
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [BYTE_W-1:0]  ram_wdata;
  logic [BYTE_W-1:0]  ram_rdata;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign key_item  = (in_data.kind == KIND_INSERT) || (in_data.kind == KIND_MATCH);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // hash start: seed at a key start, running value inside a key
  assign h0 = kip_r ? run_r : seed_r;

  // the one fold unit serves byte folding when idle and probe steps in the hash state
  assign fold_in  = (state_r == ST_HASH) ? s_r : h0;
  assign fold_add = (state_r == ST_HASH) ? '0
                  : (ADDEND_W'(in_data.key_byte) + ADDEND_W'(1));

  blf_fold u_fold (
    .s_in   (fold_in),
    .addend (fold_add),
    .s_out  (fold_out)
  );

  assign h1 = in_data.byte_valid ? fold_out : h0;

  // bit index mask, limited by the store size
  assign wmask     = (16'd1 << log2_r) - 16'd1;
  assign mask16    = wmask & FULL_MASK;
  assign probe_idx = fold_out[BIT_W-1:0] & mask_r;
  assign bit_set   = ram_rdata[bitsel_r];
  assign cnt_inc   = (ins_r && (cnt_r != TOTAL_MAX)) ? cnt_r + TOTAL_W'(1) : cnt_r;

  // ram write: zero during the sweep, set the probed bit on an insert miss
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = waddr_r;
    ram_wdata = ram_rdata | (BYTE_W'(1) << bitsel_r);
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = '0;
    end else if (state_r == ST_CHECK && !bit_set && ins_r) begin
      ram_we = 1'b1;
    end
  end

  blf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FILTER_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (probe_idx[BIT_W-1:3]),
    .rdata (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.kind == KIND_CLEAR) begin
            state_nxt = ST_CLEAR;
          end else if (key_item && in_data.last_byte) begin
            state_nxt = (probes_r == '0) ? ST_FINISH : ST_HASH;
          end
        end
      end
      ST_HASH: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if ((!bit_set && !ins_r) || remain_r == PROBE_W'(1)) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_HASH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      kip_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      seed_r      <= '0;
      log2_r      <= LOG2_W'(13);
      probes_r    <= PROBE_W'(2);
    end else begin
      state_r <= state_nxt;

      // config writes, indexes past the list are dropped
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_HASH_SEED:   seed_r   <= cfg_wdata;
          CFG_LOG2_BITS:   log2_r   <= cfg_wdata[LOG2_W-1:0];
          CFG_PROBE_COUNT: probes_r <= cfg_wdata[PROBE_W-1:0];
          default: ;
        endcase
      end

      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end

      if (in_acc) begin
        if (in_data.kind == KIND_CLEAR) begin
          kip_r     <= 1'b0;
          cnt_r     <= '0;
          clr_cnt_r <= '0;
        end else if (key_item) begin
          kip_r <= !in_data.last_byte;
        end
      end

      if (state_r == ST_FINISH && out_free) begin
        cnt_r       <= cnt_inc;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc && key_item) begin
      run_r <= h1;
      if (in_data.last_byte) begin
        s_r       <= h1;
        remain_r  <= probes_r;
        ins_r     <= (in_data.kind == KIND_INSERT);
        newly_r   <= '0;
        present_r <= 1'b1;
        mask_r    <= mask16[BIT_W-1:0];
      end
    end
    if (state_r == ST_HASH) begin
      s_r      <= fold_out;
      bitsel_r <= probe_idx[2:0];
      waddr_r  <= probe_idx[BIT_W-1:3];
    end
    if (state_r == ST_CHECK) begin
      remain_r <= remain_r - PROBE_W'(1);
      if (!bit_set) begin
        if (ins_r) begin
          newly_r <= newly_r + PROBE_W'(1);
        end else begin
          present_r <= 1'b0;
        end
      end
    end
    if (state_r == ST_FINISH && out_free) begin
      out_r.bits_newly_set <= ins_r ? newly_r : '0;
      out_r.present        <= ins_r ? 1'b0 : present_r;
      out_r.insert_total   <= cnt_inc;
    end
  end

  // a probe step is never started with no probes left
  `BLF_ASSERT(a_probe_left, clk, rst_n, (state_r == ST_HASH) |-> (remain_r != '0), "probe step with no probes left")
  // the sweep only ends after the last ram byte
  `BLF_ASSERT(a_sweep_done, clk, rst_n, (state_r == ST_CLEAR && state_nxt == ST_IDLE) |-> (clr_cnt_r == LAST_ADDR), "clear sweep ended early")
  // a match result never reports newly set bits
  `BLF_ASSERT(a_match_clean, clk, rst_n, (out_valid_r && out_r.present) |-> (out_r.bits_newly_set == '0), "match result with set bits")
  // the result register is loaded only when free
  `BLF_ASSERT(a_no_overrun, clk, rst_n, (state_r == ST_FINISH && out_valid_r && out_stall) |=> (state_r == ST_FINISH), "result loaded over a pending transfer")

endmodule

/* test/bloom_filter_lfsr_hash_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bloom filter block testbench
// streams keys into the filter, with insert, match, clear and ignored items,
// under several register settings and handshake pressure. a software copy of
// the filter predicts every result, and each result is checked field by field
// ----------------------------------------------------------------------------
module bloom_filter_lfsr_hash_top_tb;
  import blf_pkg::*;

  localparam int FILTER_BITS = FILTER_BYTES_DEF * 8;

  class filter_shadow;
    logic [HASH_W-1:0]  seed_reg;
    logic [LOG2_W-1:0]  log2_reg;
    logic [PROBE_W-1:0] probe_reg;
    logic [HASH_W-1:0]  hash_state;
    bit                 filter_bits[FILTER_BITS];
    logic [TOTAL_W-1:0] insert_total;
    bit                 key_open;
    out_item_t          answers_due[$];
    int                 mismatches;

    function new();
      seed_reg     = '0;
      log2_reg     = 4'd13;
      probe_reg    = 6'd2;
      hash_state   = '0;
      insert_total = '0;
      key_open     = 1'b0;
      mismatches   = 0;
      clear_store();
    endfunction

    function void clear_store();
      for (int b = 0; b < FILTER_BITS; b++) filter_bits[b] = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [HASH_W-1:0] data);
      unique case (idx)
        CFG_HASH_SEED:   seed_reg = data;
        CFG_LOG2_BITS:   log2_reg = data[LOG2_W-1:0];
        CFG_PROBE_COUNT: probe_reg = data[PROBE_W-1:0];
        default: ;
      endcase
    endfunction

    // one shift-and-fold step of the key hash
    function logic [HASH_W-1:0] mix_hash(logic [HASH_W-1:0] s, logic [8:0] addend);
      logic [31:0] low;
      logic [31:0] t;
      low = {19'd0, s[FOLD_BITS-1:0]};
      t = ({1'b0, s} >> FOLD_BITS) ^ (low << (HASH_W - FOLD_BITS)) ^ low;
      t = t + {23'd0, addend};
      return t[HASH_W-1:0];
    endfunction

    function void take_item(in_item_t it);
      logic [31:0]       mask;
      logic [HASH_W-1:0] s;
      int                h;
      int                i;
      int                newly;
      bit                hit;
      out_item_t         want;
      unique case (it.kind)
        KIND_CLEAR: begin
          clear_store();
          insert_total = '0;
          key_open = 1'b0;
        end
        KIND_INSERT, KIND_MATCH: begin
          if (!key_open) begin
            hash_state = seed_reg;
            key_open = 1'b1;
          end
          if (it.byte_valid) hash_state = mix_hash(hash_state, {1'b0, it.key_byte} + 9'd1);
          if (it.last_byte) begin
            key_open = 1'b0;
            // index limited by both the configured width and the store size
            mask = (FILTER_BITS - 1) & ((32'd1 << log2_reg) - 32'd1);
            s = hash_state;
            newly = 0;
            hit = 1'b1;
            i = 0;
            while (i < probe_reg && hit) begin
              s = mix_hash(s, 9'd0);
              h = s & mask;
              if (it.kind == KIND_INSERT) begin
                if (!filter_bits[h]) begin
                  filter_bits[h] = 1'b1;
                  newly++;
                end
              end else if (!filter_bits[h]) begin
                hit = 1'b0;
              end
              i++;
            end
            hash_state = s;
            if (it.kind == KIND_INSERT && insert_total != TOTAL_MAX) insert_total++;
            want.bits_newly_set = (it.kind == KIND_INSERT) ? newly[PROBE_W-1:0] : '0;
            want.present        = (it.kind == KIND_INSERT) ? 1'b0 : hit;
            want.insert_total   = insert_total;
            answers_due.push_back(want);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_answer(out_item_t got);
      out_item_t want;
      if (answers_due.size() == 0) begin
        $error("result %h arrived with none outstanding", got);
        mismatches++;
      end else begin
        want = answers_due.pop_front();
        if (got.bits_newly_set !== want.bits_newly_set) begin
          $error("bits_newly_set: expected %0d, actual %0d",
                 want.bits_newly_set, got.bits_newly_set);
          mismatches++;
        end
        if (got.present !== want.present) begin
          $error("present: expected %0d, actual %0d", want.present, got.present);
          mismatches++;
        end
        if (got.insert_total !== want.insert_total) begin
          $error("insert_total: expected %0d, actual %0d",
                 want.insert_total, got.insert_total);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return answers_due.size();
    endfunction
  endclass

  // a clear sweep walks every store byte, plus the longest probe walk
  localparam int SETTLE_CYCLES = FILTER_BYTES_DEF + 4 * 64;
  localparam int TAIL_CYCLES   = 300;
  // cycles with no transfer or register write before the run is declared hung
  localparam int QUIET_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 1900;
  localparam int PHASES        = 6;
  localparam int MAX_KEY       = 6;
  localparam int POOL_SIZE     = 24;
  // the kind code the block takes and drops
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [HASH_W-1:0]    cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;

  filter_shadow shadow;

  // idling controls; the receiver side is read in its own process
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_reqs     = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int items_sent    = 0;

  // key scratch and a pool of inserted keys for later matches
  logic [8:0] key_buf[MAX_KEY];
  int         key_len;
  logic [8:0] pool_keys[POOL_SIZE][MAX_KEY];
  int         pool_len[POOL_SIZE];

  bloom_filter_lfsr_hash_top #(
    .FILTER_BYTES(FILTER_BYTES_DEF)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side: check every transfer, then pick the next stall value
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) shadow.check_answer(out_data);
    // a new hold request starts a long stall counted here
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // hang detection: any transfer or register write counts as progress
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic in_item_t mk_item(logic [1:0] kind, logic [7:0] b, logic v, logic l);
    in_item_t it;
    it.kind       = kind;
    it.key_byte   = b;
    it.byte_valid = v;
    it.last_byte  = l;
    return it;
  endfunction

  // item of the given kind with random payload bits
  function automatic in_item_t mk_noise(logic [1:0] kind);
    return mk_item(kind, 8'($urandom), 1'($urandom), 1'($urandom));
  endfunction

  task automatic set_idling(input int mode);
    unique case (mode)
      0: begin
        send_idle_pct = 10;
        recv_idle_pct <= 78;
      end
      1: begin
        send_idle_pct = 78;
        recv_idle_pct <= 10;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
    endcase
  endtask

  // offer one item and wait for its transfer; valid stays high afterwards,
  // so the caller either offers the next item or lowers valid in this step
  task automatic send_item(input in_item_t it);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    shadow.take_item(it);
    if (it.kind != KIND_UNUSED) items_sent++;
  endtask

  // sender pause until every outstanding result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HASH_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    shadow.write_reg(idx, data);
  endtask

  // drain, let a clear sweep or probe walk finish, then write all registers;
  // unused upper data bits carry junk
  task automatic reprogram(input logic [HASH_W-1:0] seed, input logic [LOG2_W-1:0] lg,
                           input logic [PROBE_W-1:0] probes);
    logic [HASH_W-1:0] junk;
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    junk = HASH_W'($urandom);
    write_reg(CFG_HASH_SEED, seed);
    write_reg(CFG_LOG2_BITS, {junk[HASH_W-1:LOG2_W], lg});
    junk = HASH_W'($urandom);
    write_reg(CFG_PROBE_COUNT, {junk[HASH_W-1:PROBE_W], probes});
    cfg_we <= 1'b0;
  endtask

  task automatic random_key();
    key_len = $urandom_range(1, MAX_KEY);
    for (int i = 0; i < MAX_KEY; i++) begin
      key_buf[i][8]   = ($urandom_range(0, 9) != 0);
      key_buf[i][7:0] = 8'($urandom);
    end
  endtask

  // one well-formed key; mixed puts random insert/match kinds on the
  // leading bytes, noisy sprinkles dropped kind-three items in between
  task automatic send_key(input logic [1:0] kind, input bit mixed, input bit noisy);
    logic [1:0] k;
    for (int i = 0; i < key_len; i++) begin
      k = kind;
      if (mixed && i != key_len - 1) k = $urandom_range(0, 1) ? KIND_INSERT : KIND_MATCH;
      if (noisy && $urandom_range(0, 99) < 10) begin
        send_item(mk_noise(KIND_UNUSED));
      end
      send_item(mk_item(k, key_buf[i][7:0], key_buf[i][8], i == key_len - 1));
    end
  endtask

  task automatic run_phase(input int quota);
    int start;
    int r;
    int slot;
    logic [1:0] k;
    start = items_sent;
    while (items_sent - start < quota) begin
      r = $urandom_range(0, 99);
      slot = $urandom_range(0, POOL_SIZE - 1);
      if (r < 2) begin
        // clear with random payload bits
        send_item(mk_noise(KIND_CLEAR));
      end else if (r < 6) begin
        send_item(mk_noise(KIND_UNUSED));
      end else if (r < 9) begin
        // broken key: leading bytes, then a clear abandons it
        random_key();
        k = $urandom_range(0, 1) ? KIND_INSERT : KIND_MATCH;
        for (int i = 0; i < key_len; i++) begin
          send_item(mk_item(k, key_buf[i][7:0], key_buf[i][8], 1'b0));
        end
        send_item(mk_noise(KIND_CLEAR));
      end else if (r < 50) begin
        random_key();
        for (int i = 0; i < MAX_KEY; i++) pool_keys[slot][i] = key_buf[i];
        pool_len[slot] = key_len;
        send_key(KIND_INSERT, $urandom_range(0, 99) < 8, $urandom_range(0, 99) < 10);
      end else begin
        // match an inserted key most of the time so hits happen
        if (pool_len[slot] != 0 && $urandom_range(0, 99) < 60) begin
          for (int i = 0; i < MAX_KEY; i++) key_buf[i] = pool_keys[slot][i];
          key_len = pool_len[slot];
        end else begin
          random_key();
        end
        send_key(KIND_MATCH, $urandom_range(0, 99) < 8, $urandom_range(0, 99) < 10);
      end
    end
  endtask

  initial begin
    shadow = new();
    for (int i = 0; i < POOL_SIZE; i++) pool_len[i] = 0;
    set_idling(0);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed part under reset settings: seed zero, 8192 bits, two probes
    send_item(mk_item(KIND_INSERT, 8'h00, 1'b1, 1'b1));
    send_item(mk_item(KIND_MATCH,  8'h00, 1'b1, 1'b1));
    send_item(mk_item(KIND_MATCH,  8'hFF, 1'b1, 1'b1));
    // empty key: one item with no data byte
    send_item(mk_item(KIND_INSERT, 8'hFF, 1'b0, 1'b1));
    // multi-byte key with a skipped byte inside
    send_item(mk_item(KIND_INSERT, 8'hFF, 1'b1, 1'b0));
    send_item(mk_item(KIND_INSERT, 8'h00, 1'b1, 1'b0));
    send_item(mk_item(KIND_INSERT, 8'hA5, 1'b0, 1'b0));
    send_item(mk_item(KIND_INSERT, 8'h5A, 1'b1, 1'b1));
    // mixed kinds, the last item decides
    send_item(mk_item(KIND_MATCH,  8'h12, 1'b1, 1'b0));
    send_item(mk_item(KIND_INSERT, 8'h34, 1'b1, 1'b1));
    // unused kind inside a key is dropped
    send_item(mk_item(KIND_INSERT, 8'h01, 1'b1, 1'b0));
    send_item(mk_item(KIND_UNUSED, 8'hFF, 1'b1, 1'b1));
    send_item(mk_item(KIND_INSERT, 8'h02, 1'b1, 1'b1));
    // clear abandons a key in progress and empties the store
    send_item(mk_item(KIND_INSERT, 8'h77, 1'b1, 1'b0));
    send_item(mk_item(KIND_CLEAR,  8'h00, 1'b0, 1'b0));
    send_item(mk_item(KIND_MATCH,  8'h00, 1'b1, 1'b1));
    // registers change mid-key: old seed stays, width and probes take effect;
    // width above thirteen and zero probes
    send_item(mk_item(KIND_INSERT, 8'h33, 1'b1, 1'b0));
    reprogram(31'h7FFF_FFFF, 4'd14, 6'd0);
    send_item(mk_item(KIND_INSERT, 8'h44, 1'b1, 1'b1));
    send_item(mk_item(KIND_MATCH,  8'h00, 1'b1, 1'b1));
    // most probes at the widest index
    reprogram('0, 4'd15, 6'd63);
    send_item(mk_item(KIND_INSERT, 8'hC3, 1'b1, 1'b1));
    send_item(mk_item(KIND_MATCH,  8'hC3, 1'b1, 1'b1));
    // zero width: every probe lands on bit zero
    reprogram(HASH_W'($urandom), 4'd0, 6'd3);
    send_item(mk_item(KIND_INSERT, 8'h10, 1'b1, 1'b1));
    send_item(mk_item(KIND_INSERT, 8'h10, 1'b1, 1'b1));
    send_item(mk_item(KIND_MATCH,  8'h99, 1'b1, 1'b1));
    send_item(mk_item(KIND_CLEAR,  8'hFF, 1'b1, 1'b1));

    // random part: one setting per phase, idling modes in order
    for (int phase = 0; phase < PHASES; phase++) begin
      unique case (phase)
        0: reprogram(HASH_W'($urandom), 4'd13, 6'd2);
        1: reprogram(31'h7FFF_FFFF, 4'd3, 6'd1);
        2: reprogram(HASH_W'($urandom), 4'd6, 6'd32);
        3: reprogram(HASH_W'($urandom), 4'd15, 6'd63);
        4: reprogram('0, 4'd0, 6'd5);
        default: reprogram(HASH_W'($urandom), LOG2_W'($urandom_range(0, 15)),
                           PROBE_W'($urandom_range(0, 63)));
      endcase
      set_idling(phase * 3 / PHASES);
      // long receiver hold while items keep coming, so the block backs up
      if (phase == 1 || phase == 4) hold_reqs <= hold_reqs + 1;
      run_phase(RANDOM_ITEMS / PHASES / 2);
      // sender pause in the middle of the first phase until everything is back
      if (phase == 0) wait_idle();
      run_phase(RANDOM_ITEMS / PHASES - RANDOM_ITEMS / PHASES / 2);
    end

    // narrow store: insert, match, then a clear resets the insert total
    reprogram(HASH_W'($urandom), 4'd9, 6'd4);
    send_item(mk_item(KIND_INSERT, 8'h5C, 1'b1, 1'b1));
    send_item(mk_item(KIND_MATCH,  8'h5C, 1'b1, 1'b1));
    send_item(mk_item(KIND_CLEAR,  8'h00, 1'b0, 1'b1));
    send_item(mk_item(KIND_INSERT, 8'h5C, 1'b1, 1'b1));

    // drain, then a tail to catch any extra result
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (shadow.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/blf_pkg.sv
src/blf_ram.sv
src/blf_fold.sv
src/bloom_filter_lfsr_hash_top.sv
test/bloom_filter_lfsr_hash_top_tb.sv
